// ===== rtl/rsa_pkg.sv =====
// Package for the RADIUS attribute search block: shared types, register
// indexes, status codes and protocol constants. No dependencies.
`default_nettype none

package rsa_pkg;

   // Width of the reported match offset.
   localparam int OFFSET_W = 12;

   // Protocol constants of the attribute chain.
   localparam logic [7:0] VSA_TYPE         = 8'd26;
   localparam logic [7:0] VSA_MIN_LEN      = 8'd7;
   localparam logic [7:0] MIN_ATTR_LEN     = 8'd2;
   localparam logic [7:0] VENDOR_FIRST_POS = 8'd2;
   localparam logic [7:0] VENDOR_LAST_POS  = 8'd5;
   localparam logic [7:0] VENDOR_TYPE_POS  = 8'd6;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SEARCH_TYPE        = 2'd0,
      CSR_SEARCH_VENDOR      = 2'd1,
      CSR_SEARCH_VENDOR_TYPE = 2'd2,
      CSR_SKIP_COUNT         = 2'd3
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  search_type;
      logic [31:0] search_vendor;
      logic [7:0]  search_vendor_type;
      logic [7:0]  skip_count;
   } cfg_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] match_offset;
      logic [7:0]          match_length;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/rsa_csr.sv =====
// Configuration registers of the RADIUS attribute search block.
// Depends on rsa_pkg.
`default_nettype none

module rsa_csr import rsa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEARCH_TYPE:        cfg_in.search_type        = csr_write_data[7:0];
            CSR_SEARCH_VENDOR:      cfg_in.search_vendor      = csr_write_data;
            CSR_SEARCH_VENDOR_TYPE: cfg_in.search_vendor_type = csr_write_data[7:0];
            CSR_SKIP_COUNT:         cfg_in.skip_count         = csr_write_data[7:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/rsa_walk.sv =====
// Attribute chain walker: per-byte state update and match decision.
// Depends on rsa_pkg.
`default_nettype none

module rsa_walk import rsa_pkg::*; #(
   parameter int MAX_AREA_BYTES = 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   input  wire cfg_type    cfg,
   output logic            result_valid,
   output result_type      result
);

   localparam int POS_W   = $clog2(MAX_AREA_BYTES + 1);
   localparam int START_W = $clog2(MAX_AREA_BYTES);
   localparam int OFF_W   = (START_W > OFFSET_W) ? START_W : OFFSET_W;

   logic [POS_W-1:0]   pos_ff,      pos_in;
   logic [START_W-1:0] start_ff,    start_in;
   logic [7:0]         idx_ff,      idx_in;
   logic [7:0]         len_ff,      len_in;
   logic               match_ff,    match_in;
   logic [31:0]        vendor_ff,   vendor_in;
   logic [7:0]         seen_ff,     seen_in;
   logic               answered_ff, answered_in;

   logic             is_vsa;
   logic             emit;
   logic [OFF_W-1:0] off_wide;

   assign is_vsa   = (cfg.search_type == VSA_TYPE);
   assign off_wide = OFF_W'(start_ff) + (is_vsa ? OFF_W'(VENDOR_TYPE_POS) : OFF_W'(0));

   always_comb begin
      pos_in      = pos_ff;
      start_in    = start_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      match_in    = match_ff;
      vendor_in   = vendor_ff;
      seen_in     = seen_ff;
      emit        = 1'b0;
      result      = '{status: ST_NOT_FOUND, match_offset: '0, match_length: '0};

      if (!answered_ff) begin
         if (pos_ff >= POS_W'(MAX_AREA_BYTES)) begin
            // Area longer than the supported size.
            emit          = 1'b1;
            result.status = ST_MALFORMED;
         end else begin
            if (idx_ff == '0) begin
               // Type byte opens a new attribute.
               start_in  = pos_ff[START_W-1:0];
               match_in  = (data_byte == cfg.search_type);
               vendor_in = '0;
               idx_in    = 8'd1;
            end else begin
               if (idx_ff == 8'd1) begin
                  len_in = data_byte;
                  if (data_byte < MIN_ATTR_LEN) begin
                     emit          = 1'b1;
                     result.status = ST_MALFORMED;
                  end else if (is_vsa && data_byte < VSA_MIN_LEN) begin
                     match_in = 1'b0;
                  end
               end else if (is_vsa) begin
                  if (idx_ff >= VENDOR_FIRST_POS && idx_ff <= VENDOR_LAST_POS) begin
                     vendor_in = {vendor_ff[23:0], data_byte};
                  end else if (idx_ff == VENDOR_TYPE_POS) begin
                     if (vendor_ff != cfg.search_vendor ||
                         data_byte != cfg.search_vendor_type) begin
                        match_in = 1'b0;
                     end
                  end
               end
               if (!emit) begin
                  if ({1'b0, idx_ff} + 9'd1 == {1'b0, len_in}) begin
                     // Last byte of the attribute.
                     if (match_in) begin
                        if (seen_ff == cfg.skip_count) begin
                           emit                = 1'b1;
                           result.status       = ST_FOUND;
                           result.match_offset = off_wide[OFFSET_W-1:0];
                           result.match_length = len_in;
                        end else begin
                           seen_in = seen_ff + 8'd1;
                        end
                     end
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + 8'd1;
                  end
               end
            end
            pos_in = pos_ff + POS_W'(1);
         end

         if (!emit && last_byte) begin
            emit          = 1'b1;
            result.status = (idx_in == '0) ? ST_NOT_FOUND : ST_MALFORMED;
         end
      end

      answered_in = answered_ff | emit;

      if (last_byte) begin
         // Area finished: back to the reset state for the next one.
         pos_in      = '0;
         start_in    = '0;
         idx_in      = '0;
         len_in      = '0;
         match_in    = 1'b0;
         vendor_in   = '0;
         seen_in     = '0;
         answered_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         start_ff    <= '0;
         idx_ff      <= '0;
         len_ff      <= '0;
         match_ff    <= 1'b0;
         vendor_ff   <= '0;
         seen_ff     <= '0;
         answered_ff <= 1'b0;
      end else if (item_accept) begin
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         match_ff    <= match_in;
         vendor_ff   <= vendor_in;
         seen_ff     <= seen_in;
         answered_ff <= answered_in;
      end
   end

   assign result_valid = item_accept & emit;

   // The final byte of an area always leaves the walker at the area start.
   assert property (@(posedge clock) disable iff (reset)
      item_accept && last_byte |=> pos_ff == '0 && idx_ff == '0 && !answered_ff)
      else $error("walker state not cleared after final byte");

   // Once an area has been answered, no further result comes from it.
   assert property (@(posedge clock) disable iff (reset)
      item_accept && answered_ff |-> !result_valid)
      else $error("second result in one area");

   // A result either closes the area or marks it answered.
   assert property (@(posedge clock) disable iff (reset)
      result_valid && !last_byte |=> answered_ff)
      else $error("result given without marking the area answered");

   // The byte counter never runs past the supported area size.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_AREA_BYTES))
      else $error("byte position beyond area size");

endmodule

`default_nettype wire

// ===== rtl/rsa_outq.sv =====
// Two-entry result buffer (output register plus skid entry) for the
// RADIUS attribute search block. Depends on rsa_pkg.
`default_nettype none

module rsa_outq import rsa_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   input  wire logic       pop_stall,
   output logic            full,
   output logic            head_valid,
   output result_type      head
);

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = head_valid_ff & ~pop_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff) begin
         if (push) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end
      end else if (!skid_valid_ff) begin
         if (pop && push) begin
            head_in = push_data;
         end else if (pop) begin
            head_valid_in = 1'b0;
         end else if (push) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         head_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign head_valid = head_valid_ff;
   assign head       = head_ff;

   // The skid entry is only ever occupied behind a valid head.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry valid without head");

   // No result may arrive while both entries are occupied.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed into a full buffer");

   // Draining the head with a waiting skid entry keeps the head valid.
   assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> head_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on pop");

endmodule

`default_nettype wire

// ===== rtl/radius_attribute_search.sv =====
// A result is registered in the result buffer (output register or skid entry) before it appears on rsp_.
// One byte per cycle while req_stall is low; every byte is decided by one pass of compare and counter logic.
// req_stall rises only when both result slots (output register and skid entry) are full.
// Reset (synchronous, active high) clears the walker and buffer state and zeroes the
// configuration registers; configuration is kept across attribute areas.
// Top level of the RADIUS attribute search block. Depends on rsa_pkg, rsa_csr,
// rsa_walk and rsa_outq.
`default_nettype none

module radius_attribute_search import rsa_pkg::*; #(
   parameter int MAX_AREA_BYTES = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration write port.
   input  wire logic                csr_write_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_write_data,
   // Byte input channel.
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_last_byte,
   // Result channel.
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [OFFSET_W-1:0]      rsp_match_offset,
   output logic [7:0]               rsp_match_length
);

   cfg_type    cfg;
   logic       item_accept;
   logic       result_valid;
   result_type result;
   logic       buffer_full;
   result_type head;

   // The user must write the search registers only while no area is in progress; the block does not enforce this.
   rsa_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // A transaction on the input channel hands one byte of the attribute area
   // to the walker, which updates its chain state in the same cycle.
   assign item_accept = req_valid & ~req_stall;

   rsa_walk #(
      .MAX_AREA_BYTES (MAX_AREA_BYTES)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (item_accept),
      .data_byte    (req_data_byte),
      .last_byte    (req_last_byte),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   // The result buffer decouples the two channels: a byte is still taken
   // while one finished result waits on the output, and the skid entry
   // catches a second result in that case.
   rsa_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .pop_stall  (rsp_stall),
      .full       (buffer_full),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign req_stall        = buffer_full;
   assign rsp_status       = head.status;
   assign rsp_match_offset = head.match_offset;
   assign rsp_match_length = head.match_length;

endmodule

`default_nettype wire
